/* sv/ppmd_pkg.sv */
// Shared types and constants of the PPM frame decoder.
package ppmd_pkg;

    // Frame geometry.
    localparam int MAX_CHANNELS = 12;
    localparam int CNT_W        = $clog2(MAX_CHANNELS + 1);
    localparam int ADDR_W       = $clog2(MAX_CHANNELS);

    // Field widths of one transaction.
    localparam int TIME_W = 16;
    localparam int CH_W   = 4;
    localparam int OP_W   = 2;
    localparam int PH_W   = 2;

    // Configuration port.
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_START_GAP_MIN     = 3'd0,
        CFG_PULSE_WIDTH_MAX   = 3'd1,
        CFG_CHANNEL_VALUE_MIN = 3'd2,
        CFG_CHANNEL_VALUE_MAX = 3'd3,
        CFG_LOCK_FRAMES       = 3'd4,
        CFG_CHANNELS_MIN      = 3'd5,
        CFG_COUNTER_WRAP_ADD  = 3'd6
    } cfg_idx_t;

    // Register defaults after reset.
    localparam logic [TIME_W-1:0] RST_START_GAP_MIN     = 16'd2500;
    localparam logic [TIME_W-1:0] RST_PULSE_WIDTH_MAX   = 16'd500;
    localparam logic [TIME_W-1:0] RST_CHANNEL_VALUE_MIN = 16'd800;
    localparam logic [TIME_W-1:0] RST_CHANNEL_VALUE_MAX = 16'd2200;
    localparam logic [3:0]        RST_LOCK_FRAMES       = 4'd3;
    localparam logic [3:0]        RST_CHANNELS_MIN      = 4'd4;
    localparam logic [TIME_W-1:0] RST_COUNTER_WRAP_ADD  = 16'd0;

    // Operation carried in tuser.
    typedef enum logic [OP_W-1:0] {
        OP_EDGE = 2'd0,
        OP_MISS = 2'd1,
        OP_READ = 2'd2
    } op_t;

    // Synchronization phase reported with every result.
    typedef enum logic [PH_W-1:0] {
        PH_UNSYNC   = 2'd0,
        PH_ARM      = 2'd1,
        PH_ACTIVE   = 2'd2,
        PH_INACTIVE = 2'd3
    } phase_t;

endpackage

/* sv/ppm_frame_decoder.sv */
// PPM frame decoder: edge timing, frame locking and channel publishing.
// An accepted transaction passes through ST_EXEC and ST_RESP, and its result is registered;
// a frame end that publishes n channels goes through ST_COPY before ST_RESP (the copy moves
// one entry per cycle through memory). A new transaction is taken once the last result is registered.
// Reset (rst_n low, asynchronous) clears the control state, restores the register defaults
// and marks every published channel as zero; no clearing pass is needed.
module ppm_frame_decoder (
    input  logic                             clk,
    input  logic                             rst_n,
    // s_tdata: capture_count[15:0], channel_index[19:16], zero[23:20]
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [23:0]                      s_tdata,
    // s_tuser: operation[1:0]
    input  logic [ppmd_pkg::OP_W-1:0]        s_tuser,
    // m_tdata: read_value[15:0], decoded_channels[19:16], sync_phase[21:20], zero[23:22]
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [23:0]                      m_tdata,
    // Configuration write channel.
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [ppmd_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [ppmd_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import ppmd_pkg::*;

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_EXEC = 4'b0010,
        ST_COPY = 4'b0100,
        ST_RESP = 4'b1000
    } state_t;

    // Configuration registers.
    logic [TIME_W-1:0] start_gap_min_reg;
    logic [TIME_W-1:0] pulse_width_max_reg;
    logic [TIME_W-1:0] channel_value_min_reg;
    logic [TIME_W-1:0] channel_value_max_reg;
    logic [3:0]        lock_frames_reg;
    logic [3:0]        channels_min_reg;
    logic [TIME_W-1:0] counter_wrap_add_reg;

    // Control and decoder state.
    state_t            state_reg, state_next;
    logic [OP_W-1:0]   op_reg, op_next;
    logic [TIME_W-1:0] cap_reg, cap_next;
    logic [CH_W-1:0]   ch_reg, ch_next;
    logic [TIME_W-1:0] edge_time_reg, edge_time_next;
    logic [TIME_W-1:0] mark_time_reg, mark_time_next;
    logic [CNT_W-1:0]  next_slot_reg, next_slot_next;
    phase_t            phase_reg, phase_next;
    logic [CNT_W-1:0]  accepted_reg, accepted_next;
    logic [CNT_W-1:0]  candidate_reg, candidate_next;
    logic [3:0]        holdoff_reg, holdoff_next;
    logic [MAX_CHANNELS-1:0] pvalid_reg, pvalid_next;

    // Copy sequencer.
    logic [CNT_W-1:0]  copy_len_reg, copy_len_next;
    logic [CNT_W-1:0]  copy_idx_reg, copy_idx_next;
    logic              wr_pend_reg, wr_pend_next;
    logic [ADDR_W-1:0] wr_idx_reg, wr_idx_next;

    // Output register.
    logic              m_tvalid_reg, m_tvalid_next;
    logic [23:0]       m_tdata_reg, m_tdata_next;

    // Memory ports.
    logic              frame_wr_en, frame_rd_en;
    logic [TIME_W-1:0] frame_rd_data;
    logic              pub_rd_en;
    logic [TIME_W-1:0] pub_rd_data;

    // Timing arithmetic on the latched edge.
    logic [TIME_W-1:0] edge_diff;
    logic [TIME_W-1:0] gap;
    logic [TIME_W-1:0] interval;
    logic              interval_bad;
    logic              read_hit;
    logic [TIME_W-1:0] read_value;

    assign edge_diff    = cap_reg - edge_time_reg;
    assign gap          = (cap_reg < edge_time_reg) ? edge_diff + counter_wrap_add_reg
                                                    : edge_diff;
    assign interval     = cap_reg - mark_time_reg;
    assign interval_bad = (interval < channel_value_min_reg) ||
                          (interval > channel_value_max_reg);

    // A channel read returns the published value only below the accepted count.
    assign read_hit   = (op_reg == OP_READ) && (ch_reg < accepted_reg) &&
                        (ch_reg < CNT_W'(MAX_CHANNELS)) && pvalid_reg[ch_reg[ADDR_W-1:0]];
    assign read_value = read_hit ? pub_rd_data : '0;

    assign s_tready  = (state_reg == ST_IDLE);
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = m_tdata_reg;
    assign cfg_ready = 1'b1;

    // Frame store: written at the current slot, read by the copy sequencer.
    ppmd_ram #(
        .WIDTH (TIME_W),
        .DEPTH (MAX_CHANNELS)
    ) u_frame_ram (
        .clk     (clk),
        .wr_en   (frame_wr_en),
        .wr_addr (next_slot_reg[ADDR_W-1:0]),
        .wr_data (interval),
        .rd_en   (frame_rd_en),
        .rd_addr (copy_idx_reg[ADDR_W-1:0]),
        .rd_data (frame_rd_data)
    );

    // Published store: written by the copy sequencer, read by channel reads.
    ppmd_ram #(
        .WIDTH (TIME_W),
        .DEPTH (MAX_CHANNELS)
    ) u_pub_ram (
        .clk     (clk),
        .wr_en   (wr_pend_reg),
        .wr_addr (wr_idx_reg),
        .wr_data (frame_rd_data),
        .rd_en   (pub_rd_en),
        .rd_addr (ch_reg[ADDR_W-1:0]),
        .rd_data (pub_rd_data)
    );

    // Sequencer and decoder update.
    always_comb
    begin
        state_next     = state_reg;
        op_next        = op_reg;
        cap_next       = cap_reg;
        ch_next        = ch_reg;
        edge_time_next = edge_time_reg;
        mark_time_next = mark_time_reg;
        next_slot_next = next_slot_reg;
        phase_next     = phase_reg;
        accepted_next  = accepted_reg;
        candidate_next = candidate_reg;
        holdoff_next   = holdoff_reg;
        pvalid_next    = pvalid_reg;
        copy_len_next  = copy_len_reg;
        copy_idx_next  = copy_idx_reg;
        wr_pend_next   = 1'b0;
        wr_idx_next    = wr_idx_reg;
        m_tvalid_next  = m_tvalid_reg && !m_tready;
        m_tdata_next   = m_tdata_reg;
        frame_wr_en    = 1'b0;
        frame_rd_en    = 1'b0;
        pub_rd_en      = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    op_next    = s_tuser;
                    cap_next   = s_tdata[15:0];
                    ch_next    = s_tdata[19:16];
                    state_next = ST_EXEC;
                end
            end

            ST_EXEC:
            begin
                state_next = ST_RESP;
                priority case (op_reg)
                    OP_EDGE:
                    begin
                        edge_time_next = cap_reg;
                        if (gap >= start_gap_min_reg)
                        begin
                            // Frame end: lock onto the channel count or publish.
                            if (next_slot_reg != accepted_reg)
                            begin
                                if (candidate_reg != next_slot_reg)
                                begin
                                    candidate_next = next_slot_reg;
                                    holdoff_next   = lock_frames_reg;
                                end
                                else if (holdoff_reg != '0)
                                begin
                                    holdoff_next = holdoff_reg - 4'd1;
                                end
                                else
                                begin
                                    accepted_next  = candidate_reg;
                                    candidate_next = '0;
                                end
                            end
                            else if (next_slot_reg > CNT_W'(channels_min_reg))
                            begin
                                copy_len_next = next_slot_reg;
                                copy_idx_next = '0;
                                state_next    = ST_COPY;
                            end
                            next_slot_next = '0;
                            phase_next     = PH_ARM;
                        end
                        else
                        begin
                            unique case (phase_reg)
                                PH_ARM:
                                begin
                                    if (gap > pulse_width_max_reg)
                                    begin
                                        phase_next    = PH_UNSYNC;
                                        accepted_next = '0;
                                    end
                                    else
                                    begin
                                        mark_time_next = cap_reg;
                                        phase_next     = PH_INACTIVE;
                                    end
                                end
                                PH_INACTIVE:
                                begin
                                    phase_next = PH_ACTIVE;
                                end
                                PH_ACTIVE:
                                begin
                                    if (gap > pulse_width_max_reg)
                                    begin
                                        phase_next    = PH_UNSYNC;
                                        accepted_next = '0;
                                    end
                                    else
                                    begin
                                        mark_time_next = cap_reg;
                                        if (interval_bad)
                                        begin
                                            phase_next    = PH_UNSYNC;
                                            accepted_next = '0;
                                        end
                                        else
                                        begin
                                            // Marks past a full frame are checked only.
                                            if (next_slot_reg < CNT_W'(MAX_CHANNELS))
                                            begin
                                                frame_wr_en    = 1'b1;
                                                next_slot_next = next_slot_reg + 1'b1;
                                            end
                                            phase_next = PH_INACTIVE;
                                        end
                                    end
                                end
                                PH_UNSYNC:
                                begin
                                end
                            endcase
                        end
                    end
                    OP_MISS:
                    begin
                        phase_next    = PH_UNSYNC;
                        accepted_next = '0;
                    end
                    OP_READ:
                    begin
                        pub_rd_en = (ch_reg < CNT_W'(MAX_CHANNELS));
                    end
                    default:
                    begin
                    end
                endcase
            end

            ST_COPY:
            begin
                // Read entry k while writing entry k-1 of the previous read.
                if (wr_pend_reg)
                begin
                    pvalid_next[wr_idx_reg] = 1'b1;
                end
                if (copy_idx_reg < copy_len_reg)
                begin
                    frame_rd_en   = 1'b1;
                    wr_pend_next  = 1'b1;
                    wr_idx_next   = copy_idx_reg[ADDR_W-1:0];
                    copy_idx_next = copy_idx_reg + 1'b1;
                end
                else if (!wr_pend_reg)
                begin
                    state_next = ST_RESP;
                end
            end

            ST_RESP:
            begin
                if (!m_tvalid_reg || m_tready)
                begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = {2'b00, phase_reg, accepted_reg, read_value};
                    state_next    = ST_IDLE;
                end
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            edge_time_reg <= '0;
            mark_time_reg <= '0;
            next_slot_reg <= '0;
            phase_reg     <= PH_UNSYNC;
            accepted_reg  <= '0;
            candidate_reg <= '0;
            holdoff_reg   <= '0;
            pvalid_reg    <= '0;
            copy_len_reg  <= '0;
            copy_idx_reg  <= '0;
            wr_pend_reg   <= 1'b0;
            m_tvalid_reg  <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            edge_time_reg <= edge_time_next;
            mark_time_reg <= mark_time_next;
            next_slot_reg <= next_slot_next;
            phase_reg     <= phase_next;
            accepted_reg  <= accepted_next;
            candidate_reg <= candidate_next;
            holdoff_reg   <= holdoff_next;
            pvalid_reg    <= pvalid_next;
            copy_len_reg  <= copy_len_next;
            copy_idx_reg  <= copy_idx_next;
            wr_pend_reg   <= wr_pend_next;
            m_tvalid_reg  <= m_tvalid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        op_reg      <= op_next;
        cap_reg     <= cap_next;
        ch_reg      <= ch_next;
        wr_idx_reg  <= wr_idx_next;
        m_tdata_reg <= m_tdata_next;
    end

    // Configuration registers; an index beyond the list is ignored.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_gap_min_reg     <= RST_START_GAP_MIN;
            pulse_width_max_reg   <= RST_PULSE_WIDTH_MAX;
            channel_value_min_reg <= RST_CHANNEL_VALUE_MIN;
            channel_value_max_reg <= RST_CHANNEL_VALUE_MAX;
            lock_frames_reg       <= RST_LOCK_FRAMES;
            channels_min_reg      <= RST_CHANNELS_MIN;
            counter_wrap_add_reg  <= RST_COUNTER_WRAP_ADD;
        end
        else if (cfg_valid && cfg_ready)
        begin
            priority case (cfg_index)
                CFG_START_GAP_MIN:     start_gap_min_reg     <= cfg_data;
                CFG_PULSE_WIDTH_MAX:   pulse_width_max_reg   <= cfg_data;
                CFG_CHANNEL_VALUE_MIN: channel_value_min_reg <= cfg_data;
                CFG_CHANNEL_VALUE_MAX: channel_value_max_reg <= cfg_data;
                CFG_LOCK_FRAMES:       lock_frames_reg       <= cfg_data[3:0];
                CFG_CHANNELS_MIN:      channels_min_reg      <= cfg_data[3:0];
                CFG_COUNTER_WRAP_ADD:  counter_wrap_add_reg  <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

endmodule

/* sv/ppmd_ram.sv */
// Generic single-write, single-read RAM with a registered read port.
module ppmd_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 12
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // Write port and registered read port; read data holds between reads.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

/* sv/ppmd_checker.sv */
// Port-level checks of the PPM frame decoder and their binding to it.
module ppmd_checker (
    input logic                             clk,
    input logic                             rst_n,
    input logic                             s_tvalid,
    input logic                             s_tready,
    input logic [23:0]                      s_tdata,
    input logic [ppmd_pkg::OP_W-1:0]        s_tuser,
    input logic                             m_tvalid,
    input logic                             m_tready,
    input logic [23:0]                      m_tdata,
    input logic                             cfg_valid,
    input logic                             cfg_ready,
    input logic [ppmd_pkg::CFG_IDX_W-1:0]   cfg_index,
    input logic [ppmd_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import ppmd_pkg::*;

    // A stalled result holds its value.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // Losing sync always drops the accepted channel count.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tdata[21:20] == PH_UNSYNC) |-> (m_tdata[19:16] == 4'd0))
        else $error("unsynchronized with a nonzero channel count");

    // The accepted count never exceeds the frame capacity.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[19:16] <= 4'(MAX_CHANNELS)))
        else $error("channel count beyond capacity");

    // A nonzero channel value needs an accepted channel count.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tdata[15:0] != 16'd0) |-> (m_tdata[19:16] != 4'd0))
        else $error("channel value reported without signal");

endmodule

bind ppm_frame_decoder ppmd_checker u_ppmd_checker (.*);

/* tb/tb_ppm_frame_decoder.sv */
// Self-checking testbench of the PPM frame decoder with a built-in behavioral predictor.
module tb_ppm_frame_decoder;
    timeunit 1ns;
    timeprecision 1ps;

    import ppmd_pkg::*;

    localparam int          CLK_HALF       = 6;
    localparam int          RESET_CYCLES   = 7;
    localparam int          SETTLE_CYCLES  = 24;
    localparam int          HOLDOFF_CYCLES = 400;
    localparam int unsigned CYCLE_LIMIT    = 1_000_000;

    // Operation code that the block ignores apart from reporting its status.
    localparam logic [OP_W-1:0] OP_RESERVED = 2'd3;

    // One input transaction before packing.
    typedef struct packed {
        logic [OP_W-1:0]   op;
        logic [TIME_W-1:0] stamp;
        logic [CH_W-1:0]   chan;
    } ppm_item_t;

    // One status report of the block.
    typedef struct {
        logic [TIME_W-1:0] read_value;
        logic [CH_W-1:0]   decoded_channels;
        phase_t            sync_phase;
    } ppm_status_t;

    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [23:0]           s_tdata   = '0;
    logic [OP_W-1:0]       s_tuser   = '0;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [23:0]           m_tdata;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;

    // Traffic control.
    ppm_item_t   ppm_items[$];
    ppm_status_t due_reports[$];
    int unsigned queued_total  = 0;
    int unsigned src_idle_pct  = 25;
    int unsigned rx_idle_pct   = 51;
    int unsigned error_count   = 0;
    int unsigned cycle_count   = 0;
    bit          in_taken      = 1'b0;
    bit          tx_pause      = 1'b0;
    bit          rx_hold       = 1'b0;
    bit          rx_hold_go    = 1'b0;
    logic [TIME_W-1:0] stim_time = '0;

    // Predictor copy of the registers.
    logic [TIME_W-1:0] reg_start_gap   = RST_START_GAP_MIN;
    logic [TIME_W-1:0] reg_pulse_max   = RST_PULSE_WIDTH_MAX;
    logic [TIME_W-1:0] reg_chan_min    = RST_CHANNEL_VALUE_MIN;
    logic [TIME_W-1:0] reg_chan_max    = RST_CHANNEL_VALUE_MAX;
    logic [3:0]        reg_lock_frames = RST_LOCK_FRAMES;
    logic [3:0]        reg_chan_floor  = RST_CHANNELS_MIN;
    logic [TIME_W-1:0] reg_wrap_add    = RST_COUNTER_WRAP_ADD;

    // Predictor copy of the decoder state.
    logic [TIME_W-1:0] edge_stamp = '0;
    logic [TIME_W-1:0] mark_stamp = '0;
    int unsigned       slot_count = 0;
    int unsigned       lock_count = 0;
    int unsigned       cand_count = 0;
    int unsigned       holdoff    = 0;
    phase_t            sync_state = PH_UNSYNC;
    logic [TIME_W-1:0] frame_vals [MAX_CHANNELS] = '{default: '0};
    logic [TIME_W-1:0] pub_vals   [MAX_CHANNELS] = '{default: '0};

    ppm_frame_decoder dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Clock generation.
    initial
    begin
        forever #(CLK_HALF) clk = ~clk;
    end

    function automatic int unsigned lesser(int unsigned a, int unsigned b);
        return (a < b) ? a : b;
    endfunction

    // Loss of synchronization keeps the slot, candidate and holdoff counters.
    task automatic drop_sync();
        sync_state = PH_UNSYNC;
        lock_count = 0;
    endtask

    // Frame end: lock onto a new channel count or publish a matching frame.
    task automatic close_frame();
        if (slot_count != lock_count)
        begin
            if (cand_count != slot_count)
            begin
                cand_count = slot_count;
                holdoff    = reg_lock_frames;
            end
            else if (holdoff > 0)
            begin
                holdoff--;
            end
            else
            begin
                lock_count = cand_count;
                cand_count = 0;
            end
        end
        else if (slot_count > reg_chan_floor)
        begin
            for (int k = 0; k < slot_count && k < MAX_CHANNELS; k++)
                pub_vals[k] = frame_vals[k];
        end
        slot_count = 0;
        sync_state = PH_ARM;
    endtask

    // Timing of one captured edge.
    task automatic take_edge(logic [TIME_W-1:0] stamp);
        logic [TIME_W-1:0] gap;
        logic [TIME_W-1:0] interval;
        gap = stamp - edge_stamp;
        if (stamp < edge_stamp)
            gap = gap + reg_wrap_add;
        edge_stamp = stamp;
        if (gap >= reg_start_gap)
        begin
            close_frame();
            return;
        end
        case (sync_state)
            PH_ARM:
            begin
                if (gap > reg_pulse_max)
                begin
                    drop_sync();
                end
                else
                begin
                    mark_stamp = stamp;
                    sync_state = PH_INACTIVE;
                end
            end
            PH_INACTIVE:
            begin
                sync_state = PH_ACTIVE;
            end
            PH_ACTIVE:
            begin
                if (gap > reg_pulse_max)
                begin
                    drop_sync();
                    return;
                end
                interval   = stamp - mark_stamp;
                mark_stamp = stamp;
                if (interval < reg_chan_min || interval > reg_chan_max)
                begin
                    drop_sync();
                    return;
                end
                // Marks beyond a full frame are checked but not stored.
                if (slot_count < MAX_CHANNELS)
                begin
                    frame_vals[slot_count] = interval;
                    slot_count++;
                end
                sync_state = PH_INACTIVE;
            end
            default: ;
        endcase
    endtask

    // Update the predicted state with one accepted transaction and queue its report.
    task automatic track_item(logic [OP_W-1:0] op, logic [TIME_W-1:0] stamp,
                              logic [CH_W-1:0] chan);
        ppm_status_t status;
        status.read_value = '0;
        case (op)
            OP_EDGE: take_edge(stamp);
            OP_MISS: drop_sync();
            OP_READ:
            begin
                if (chan < lock_count && chan < MAX_CHANNELS)
                    status.read_value = pub_vals[chan];
            end
            default: ;
        endcase
        status.decoded_channels = lock_count[CH_W-1:0];
        status.sync_phase       = sync_state;
        due_reports.push_back(status);
    endtask

    // Input side: launch the next transaction once the current one is taken.
    always @(negedge clk)
    begin : source_driver
        ppm_item_t item;
        if (!s_tvalid || in_taken)
        begin
            if (rst_n && ppm_items.size() != 0 && !tx_pause &&
                $urandom_range(99) >= src_idle_pct)
            begin
                item = ppm_items.pop_front();
                s_tdata  <= {4'd0, item.chan, item.stamp};
                s_tuser  <= item.op;
                s_tvalid <= 1'b1;
            end
            else
            begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // Output side: random back-pressure plus the long hold-off.
    always @(negedge clk)
    begin : sink_driver
        m_tready <= rst_n && !rx_hold && ($urandom_range(99) >= rx_idle_pct);
    end

    // Observe both sides: predict on input transactions, check output transactions.
    always @(posedge clk)
    begin : monitor
        ppm_status_t want;
        in_taken <= rst_n && s_tvalid && s_tready;
        if (rst_n)
        begin
            if (s_tvalid && s_tready)
                track_item(s_tuser, s_tdata[15:0], s_tdata[19:16]);
            if (m_tvalid && m_tready)
            begin
                if (due_reports.size() == 0)
                begin
                    $error("unexpected result transaction, m_tdata %h", m_tdata);
                    error_count++;
                end
                else
                begin
                    want = due_reports.pop_front();
                    if (m_tdata[15:0] !== want.read_value)
                    begin
                        $error("read_value: expected %0d, actual %0d",
                               want.read_value, m_tdata[15:0]);
                        error_count++;
                    end
                    if (m_tdata[19:16] !== want.decoded_channels)
                    begin
                        $error("decoded_channels: expected %0d, actual %0d",
                               want.decoded_channels, m_tdata[19:16]);
                        error_count++;
                    end
                    if (m_tdata[21:20] !== want.sync_phase)
                    begin
                        $error("sync_phase: expected %0d, actual %0d",
                               want.sync_phase, m_tdata[21:20]);
                        error_count++;
                    end
                end
            end
        end
    end

    // Run limit.
    always @(posedge clk)
    begin : watchdog
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("tb_ppm_frame_decoder: FAIL");
            $finish;
        end
    end

    // Long receiver hold-off so the block fills up and stalls its input.
    initial
    begin : sink_holdoff
        wait (rx_hold_go);
        rx_hold = 1'b1;
        repeat (HOLDOFF_CYCLES) @(posedge clk);
        rx_hold = 1'b0;
    end

    function automatic void push_item(logic [OP_W-1:0] op, logic [TIME_W-1:0] stamp,
                                      logic [CH_W-1:0] chan);
        ppm_items.push_back(ppm_item_t'{op: op, stamp: stamp, chan: chan});
        queued_total++;
    endfunction

    function automatic void push_edge(int unsigned gap);
        stim_time = stim_time + gap[TIME_W-1:0];
        push_item(OP_EDGE, stim_time, CH_W'($urandom_range(15)));
    endfunction

    // One frame timed from the current registers; a flaw breaks one channel.
    // Flaw 0 none, 1 interval too long, 2 interval too short, 3 pulse too long,
    // 4 missed edge inside the frame.
    task automatic gen_frame(int unsigned n, int unsigned flaw);
        int unsigned flaw_at;
        int unsigned hi;
        int unsigned lo;
        int unsigned val;
        int unsigned width;
        int unsigned gap_cap;
        flaw_at = (n > 0) ? $urandom_range(n - 1) : 0;
        gap_cap = (reg_start_gap > 0) ? reg_start_gap - 1 : 0;
        hi = lesser(reg_start_gap + 2000, 65535);
        push_edge($urandom_range(hi, reg_start_gap));
        push_edge($urandom_range(lesser(reg_pulse_max, gap_cap), 0));
        for (int k = 0; k < n; k++)
        begin
            val = $urandom_range(reg_chan_max, reg_chan_min);
            if (flaw == 1 && k == flaw_at && reg_chan_max < 65535)
                val = lesser(reg_chan_max + 1 + $urandom_range(300), 65535);
            if (flaw == 2 && k == flaw_at && reg_chan_min > 0)
                val = $urandom_range(reg_chan_min - 1);
            // Keep the space before the mark shorter than a frame start.
            lo    = (val > gap_cap) ? val - gap_cap : 0;
            hi    = lesser(lesser(reg_pulse_max, val), gap_cap);
            width = (lo > hi) ? hi : $urandom_range(hi, lo);
            if (flaw == 3 && k == flaw_at && reg_pulse_max < 65535)
                width = lesser(reg_pulse_max + 1 + $urandom_range(200), 65535);
            push_edge((val > width) ? val - width : 0);
            if (flaw == 4 && k == flaw_at)
                push_item(OP_MISS, TIME_W'($urandom), CH_W'($urandom_range(15)));
            push_edge(width);
        end
    endtask

    // Random traffic: mostly well-formed frame runs, then broken frames, reads and noise.
    task automatic fill_random(int unsigned count);
        int unsigned goal;
        int unsigned pick;
        int unsigned n;
        int unsigned frames;
        logic [OP_W-1:0]   op;
        logic [TIME_W-1:0] stamp;
        goal = queued_total + count;
        while (queued_total < goal)
        begin
            pick = $urandom_range(99);
            if (pick < 55)
            begin
                n      = ($urandom_range(3) == 0) ? $urandom_range(14) : $urandom_range(8);
                frames = $urandom_range(reg_lock_frames + 4, 1);
                repeat (frames)
                begin
                    // A run ends early once the item budget is spent.
                    if (queued_total >= goal)
                        break;
                    gen_frame(n, 0);
                    if ($urandom_range(9) < 3)
                        push_item(OP_READ, TIME_W'($urandom), CH_W'($urandom_range(15)));
                end
            end
            else if (pick < 70)
            begin
                gen_frame($urandom_range(12), $urandom_range(4, 1));
            end
            else if (pick < 85)
            begin
                repeat ($urandom_range(6, 1))
                    push_item(OP_READ, TIME_W'($urandom), CH_W'($urandom_range(15)));
            end
            else
            begin
                repeat ($urandom_range(8, 1))
                begin
                    op    = OP_W'($urandom_range(3));
                    stamp = TIME_W'($urandom);
                    push_item(op, stamp, CH_W'($urandom_range(15)));
                    if (op == OP_EDGE)
                        stim_time = stamp;
                end
            end
        end
    endtask

    // Configuration write transaction; the predictor takes it when accepted.
    task automatic write_reg(cfg_idx_t idx, logic [CFG_DATA_W-1:0] val);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        case (idx)
            CFG_START_GAP_MIN:     reg_start_gap   = val;
            CFG_PULSE_WIDTH_MAX:   reg_pulse_max   = val;
            CFG_CHANNEL_VALUE_MIN: reg_chan_min    = val;
            CFG_CHANNEL_VALUE_MAX: reg_chan_max    = val;
            CFG_LOCK_FRAMES:       reg_lock_frames = val[3:0];
            CFG_CHANNELS_MIN:      reg_chan_floor  = val[3:0];
            CFG_COUNTER_WRAP_ADD:  reg_wrap_add    = val;
            default: ;
        endcase
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic program_regs(logic [15:0] start_gap, logic [15:0] pulse_max,
                                logic [15:0] chan_min, logic [15:0] chan_max,
                                logic [3:0] lock_frames, logic [3:0] chan_floor,
                                logic [15:0] wrap_add);
        write_reg(CFG_START_GAP_MIN, start_gap);
        write_reg(CFG_PULSE_WIDTH_MAX, pulse_max);
        write_reg(CFG_CHANNEL_VALUE_MIN, chan_min);
        write_reg(CFG_CHANNEL_VALUE_MAX, chan_max);
        write_reg(CFG_LOCK_FRAMES, {12'd0, lock_frames});
        write_reg(CFG_CHANNELS_MIN, {12'd0, chan_floor});
        write_reg(CFG_COUNTER_WRAP_ADD, wrap_add);
    endtask

    // Wait until the last report is in and the block has settled.
    task automatic wait_results();
        while (s_tvalid || due_reports.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic drain();
        while (ppm_items.size() != 0) @(posedge clk);
        wait_results();
    endtask

    // Test sequence.
    initial
    begin : stimulus
        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed part: default timing with a timer wrap offset.
        program_regs(16'd2500, 16'd500, 16'd800, 16'd2200, 4'd3, 4'd4, 16'd1000);
        push_item(OP_READ, 16'hFFFF, 4'd0);
        push_item(OP_RESERVED, 16'hFFFF, 4'hF);
        // Short gap while unsynchronized only moves the edge time.
        push_item(OP_EDGE, 16'd100, 4'hF);
        push_item(OP_EDGE, 16'hFFFF, 4'd0);
        // Wrapped timer: the offset makes the pulse too long.
        push_item(OP_EDGE, 16'h0000, 4'd0);
        push_item(OP_EDGE, 16'd3000, 4'd5);
        push_item(OP_EDGE, 16'd3300, 4'd10);
        // Inactive edge is not timed; the next mark stores one channel.
        push_item(OP_EDGE, 16'd4400, 4'd3);
        push_item(OP_EDGE, 16'd4800, 4'd12);
        // Channel interval below the minimum.
        push_item(OP_EDGE, 16'd4900, 4'd1);
        push_item(OP_EDGE, 16'd5000, 4'd2);
        // Frame end with a stale slot count, then a pulse that is too long.
        push_item(OP_EDGE, 16'd7600, 4'd0);
        push_item(OP_EDGE, 16'd8200, 4'd0);
        push_item(OP_MISS, 16'h0000, 4'd0);
        push_item(OP_READ, 16'h0000, 4'hF);
        // Channel interval above the maximum.
        push_item(OP_EDGE, 16'd11000, 4'd7);
        push_item(OP_EDGE, 16'd11300, 4'd8);
        push_item(OP_EDGE, 16'd13300, 4'd9);
        push_item(OP_EDGE, 16'd13700, 4'd11);
        push_item(OP_MISS, 16'hA5A5, 4'd6);
        push_item(OP_RESERVED, 16'h0000, 4'd0);
        stim_time = 16'd13700;
        drain();

        // Default timing; the receiver stalls for a long stretch.
        program_regs(16'd2500, 16'd500, 16'd800, 16'd2200, 4'd3, 4'd4, 16'd0);
        fill_random(480);
        rx_hold_go = 1'b1;
        drain();

        // Wide limits, immediate lock; the sender pauses until all reports are in.
        src_idle_pct = 51;
        rx_idle_pct  = 25;
        program_regs(16'd4000, 16'hFFFF, 16'd0, 16'd3000, 4'd0, 4'd0, 16'hFFFF);
        fill_random(480);
        while (ppm_items.size() > 240) @(posedge clk);
        tx_pause = 1'b1;
        wait_results();
        tx_pause = 1'b0;
        drain();

        // Tight limits, slowest lock, no publishing; no idling from here on.
        src_idle_pct = 0;
        rx_idle_pct  = 0;
        program_regs(16'd3000, 16'd300, 16'd1000, 16'd2000, 4'd15, 4'd12, 16'd12345);
        fill_random(450);
        drain();

        // Largest frame start, zero pulse width and the full value range.
        program_regs(16'hFFFF, 16'd0, 16'd0, 16'hFFFF, 4'd1, 4'd1, 16'd0);
        fill_random(120);
        drain();

        if (error_count == 0)
            $display("tb_ppm_frame_decoder: PASS");
        else
            $display("tb_ppm_frame_decoder: FAIL");
        $finish;
    end

endmodule
